/* src/wmac_pkg.sv */
package wmac_pkg;

  // Field widths of the channels and the configuration register.
  localparam int PRICE_W  = 32;
  localparam int CHANGE_W = 33;
  localparam int PCT_W    = 48;
  localparam int WIN_W    = 8;

  // Reset value of the window length register.
  localparam logic [WIN_W-1:0] WIN_RESET = 8'd20;

  // Percent scale: 100 with 16 fractional bits.
  localparam int PCT_SCALE_W = 23;
  localparam logic [PCT_SCALE_W-1:0] PCT_SCALE = 23'd6553600;

  // Shared divider operand widths. The dividend covers the scaled change
  // and the widest window sum.
  localparam int DIV_N_W = PRICE_W + PCT_SCALE_W;
  localparam int DIV_D_W = PRICE_W;

  // Saturation limits of the percent change, as quotient magnitudes.
  localparam logic [DIV_N_W-1:0] PCT_MAX     = DIV_N_W'(64'h7FFF_FFFF_FFFF);
  localparam logic [DIV_N_W-1:0] PCT_MIN_MAG = DIV_N_W'(64'h8000_0000_0000);

endpackage

/* src/wmac_hist.sv */
module wmac_hist #(
  parameter int DEPTH = 128
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr_i,
  input  logic [wmac_pkg::PRICE_W-1:0]      wr_data_i,
  input  logic                              rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr_i,
  output logic [wmac_pkg::PRICE_W-1:0]      rd_data_o
);

  logic [wmac_pkg::PRICE_W-1:0] mem_q [DEPTH];
  logic [wmac_pkg::PRICE_W-1:0] rd_data_q;

  // Price history: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/wmac_div.sv */
module wmac_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [wmac_pkg::DIV_N_W-1:0]     dividend_i,
  input  logic [wmac_pkg::DIV_D_W-1:0]     divisor_i,
  output logic                             done_o,
  output logic [wmac_pkg::DIV_N_W-1:0]     quotient_o
);

  localparam int N_W   = wmac_pkg::DIV_N_W;
  localparam int D_W   = wmac_pkg::DIV_D_W;
  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N_W-1:0]   quo_q;
  logic [D_W-1:0]   rem_q;
  logic [D_W-1:0]   div_q;

  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             fits;
  logic [D_W-1:0]   rem_d;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[N_W-1]};
    diff  = trial - {1'b0, div_q};
    fits  = trial >= {1'b0, div_q};
    rem_d = fits ? diff[D_W-1:0] : trial[D_W-1:0];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[N_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* src/windowed_moving_average_with_change_core.sv */
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | in_valid_i, in_stall_o, price_sample_i    | input word
// out      | out_valid_o, out_stall_i, moving_average_o,| result word
//          | price_change_o, percent_change_o          |
// cfg      | cfg_valid_i, cfg_ready_o, cfg_window_length_i | register write
//
// A word is worked on alone until its result moves to the output register. The window
// sum of count = min(window, samples held) entries, a window of zero counting as one,
// is read from the history memory one entry per cycle, then the shared bit-serial
// divider runs 55 steps for the mean and 55 for the percent change. Without a usable
// previous price the second division is skipped. After reset the block is ready at once.
// in_stall_o is high while a word is in work or its result waits for the output register.
module windowed_moving_average_with_change_core #(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [wmac_pkg::PRICE_W-1:0]         price_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [wmac_pkg::PRICE_W-1:0]         moving_average_o,
  output logic signed [wmac_pkg::CHANGE_W-1:0] price_change_o,
  output logic signed [wmac_pkg::PCT_W-1:0]    percent_change_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wmac_pkg::WIN_W-1:0]           cfg_window_length_i
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = (CNT_W > wmac_pkg::WIN_W) ? CNT_W : wmac_pkg::WIN_W;
  localparam int SUM_W = wmac_pkg::PRICE_W + CNT_W;
  localparam int N_W   = wmac_pkg::DIV_N_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SUM      = 4'd1;
  localparam logic [3:0] S_AVG_GO   = 4'd2;
  localparam logic [3:0] S_AVG_WAIT = 4'd3;
  localparam logic [3:0] S_PCT_MUL  = 4'd4;
  localparam logic [3:0] S_PCT_GO   = 4'd5;
  localparam logic [3:0] S_PCT_WAIT = 4'd6;
  localparam logic [3:0] S_DONE     = 4'd7;

  logic [3:0]                   state_q;
  logic [PTR_W-1:0]             wp_q;
  logic [CNT_W-1:0]             seen_q;
  logic [wmac_pkg::PRICE_W-1:0] prev_q;
  logic [wmac_pkg::WIN_W-1:0]   win_len_q;
  logic [CNT_W-1:0]             issue_cnt_q;
  logic [PTR_W-1:0]             rd_ptr_q;
  logic                         rd_vld_q;
  logic                         out_vld_q;

  logic [SUM_W-1:0]             window_sum_q;
  logic [CNT_W-1:0]             count_q;
  logic                         neg_q;
  logic                         pct_ok_q;
  logic [wmac_pkg::PRICE_W-1:0] mag_q;
  logic [wmac_pkg::PRICE_W-1:0] base_q;
  logic [N_W-1:0]               prod_q;
  logic [wmac_pkg::PRICE_W-1:0] avg_q;
  logic [wmac_pkg::CHANGE_W-1:0] change_q;
  logic [wmac_pkg::PCT_W-1:0]   pct_q;
  logic [wmac_pkg::PRICE_W-1:0] res_avg_q;
  logic [wmac_pkg::CHANGE_W-1:0] res_change_q;
  logic [wmac_pkg::PCT_W-1:0]   res_pct_q;

  logic                         accept;
  logic                         load_out;
  logic                         rd_en;
  logic [wmac_pkg::PRICE_W-1:0] rd_data;
  logic [CNT_W-1:0]             seen_d;
  logic [CNT_W-1:0]             count_d;
  logic [CMP_W-1:0]             win_ext;
  logic [CMP_W-1:0]             win_sat;
  logic [CMP_W-1:0]             seen_ext;
  logic [CMP_W-1:0]             depth_ext;
  logic [wmac_pkg::CHANGE_W-1:0] diff;
  logic                         div_start;
  logic                         div_done;
  logic [N_W-1:0]               div_dividend;
  logic [wmac_pkg::DIV_D_W-1:0] div_divisor;
  logic [N_W-1:0]               quotient;
  logic [N_W-1:0]               pct_mag;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_vld_q;
  assign cfg_ready_o = 1'b1;
  assign rd_en       = (state_q == S_SUM) && (issue_cnt_q != '0);

  // A finished word moves to the output register once that register is free or drains.
  assign load_out    = (state_q == S_DONE) && (!out_vld_q || !out_stall_i);

  // Samples held after this word, and the number of entries to average.
  always_comb begin
    depth_ext = CMP_W'(HISTORY_DEPTH);
    seen_d    = (seen_q == CNT_W'(HISTORY_DEPTH)) ? seen_q : seen_q + CNT_W'(1);
    win_ext   = (win_len_q == '0) ? CMP_W'(1) : CMP_W'(win_len_q);
    win_sat   = (win_ext > depth_ext) ? depth_ext : win_ext;
    seen_ext  = CMP_W'(seen_d);
    count_d   = (win_sat < seen_ext) ? CNT_W'(win_sat) : seen_d;
    diff      = {1'b0, price_sample_i} - {1'b0, prev_q};
  end

  // Divider operands: the window sum first, the scaled change second.
  always_comb begin
    div_start    = (state_q == S_AVG_GO) || (state_q == S_PCT_GO);
    div_dividend = (state_q == S_AVG_GO) ? N_W'(window_sum_q) : prod_q;
    div_divisor  = (state_q == S_AVG_GO) ? wmac_pkg::DIV_D_W'(count_q) : base_q;
    if (neg_q) begin
      pct_mag = (quotient > wmac_pkg::PCT_MIN_MAG) ? wmac_pkg::PCT_MIN_MAG : quotient;
    end else begin
      pct_mag = (quotient > wmac_pkg::PCT_MAX) ? wmac_pkg::PCT_MAX : quotient;
    end
  end

  wmac_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (wp_q),
    .wr_data_i (price_sample_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_ptr_q),
    .rd_data_o (rd_data)
  );

  wmac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Sequencer and history bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      seen_q      <= '0;
      prev_q      <= '0;
      win_len_q   <= wmac_pkg::WIN_RESET;
      issue_cnt_q <= '0;
      rd_ptr_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cfg_valid_i) begin
        win_len_q <= cfg_window_length_i;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            wp_q        <= (wp_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
            seen_q      <= seen_d;
            prev_q      <= price_sample_i;
            issue_cnt_q <= count_d;
            rd_ptr_q    <= wp_q;
            state_q     <= S_SUM;
          end
        end
        S_SUM: begin
          if (rd_en) begin
            issue_cnt_q <= issue_cnt_q - CNT_W'(1);
            rd_ptr_q    <= (rd_ptr_q == '0) ? PTR_W'(HISTORY_DEPTH - 1) : rd_ptr_q - PTR_W'(1);
          end else if (!rd_vld_q) begin
            state_q <= S_AVG_GO;
          end
        end
        S_AVG_GO: begin
          state_q <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            state_q <= pct_ok_q ? S_PCT_MUL : S_DONE;
          end
        end
        S_PCT_MUL: begin
          state_q <= S_PCT_GO;
        end
        S_PCT_GO: begin
          state_q <= S_PCT_WAIT;
        end
        S_PCT_WAIT: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: window accumulation, change, product and result words.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      window_sum_q <= '0;
      count_q      <= count_d;
      neg_q        <= diff[wmac_pkg::CHANGE_W-1];
      pct_ok_q     <= (seen_q != '0) && (prev_q != '0);
      mag_q        <= diff[wmac_pkg::CHANGE_W-1] ? (prev_q - price_sample_i)
                                                 : (price_sample_i - prev_q);
      base_q       <= prev_q;
      change_q     <= (seen_q != '0) ? diff : '0;
      pct_q        <= '0;
    end
    if (rd_vld_q) begin
      window_sum_q <= window_sum_q + SUM_W'(rd_data);
    end
    if (state_q == S_PCT_MUL) begin
      prod_q <= mag_q * wmac_pkg::PCT_SCALE;
    end
    if ((state_q == S_AVG_WAIT) && div_done) begin
      avg_q <= quotient[wmac_pkg::PRICE_W-1:0];
    end
    if ((state_q == S_PCT_WAIT) && div_done) begin
      pct_q <= neg_q ? wmac_pkg::PCT_W'(N_W'(0) - pct_mag) : wmac_pkg::PCT_W'(pct_mag);
    end
    if (load_out) begin
      res_avg_q    <= avg_q;
      res_change_q <= change_q;
      res_pct_q    <= pct_q;
    end
  end

  assign moving_average_o = res_avg_q;
  assign price_change_o   = res_change_q;
  assign percent_change_o = res_pct_q;

endmodule
